// ----- design/snf_pkg.sv -----
// Shared widths, constants and types for the sigmoid neuron forward block.
`timescale 1ns / 1ps
package snf_pkg;

   localparam int SIGMOID_ENTRIES_DEFAULT = 1024;

   localparam int VALUE_W     = 16;
   localparam int PROD_W      = 2 * VALUE_W;
   localparam int ACC_W       = 48;
   localparam int SUM_W       = 42;
   localparam int ACT_W       = 16;
   localparam int ARG_W       = 16;
   localparam int ARG_LSB     = 12;
   localparam int REQ_TDATA_W = 2 * VALUE_W;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_PAD_W   = RSP_TDATA_W - SUM_W - ACT_W;

   // +8.0 in Q8.24
   localparam logic signed [ACC_W-1:0] ARG_LIMIT = 48'sh0000_0800_0000;

   typedef struct packed {
      logic [SUM_W-1:0] dot_sum;
      logic             argument_clamped;
      logic [ARG_W-1:0] arg_offset;
   } snf_sum_type;

endpackage

// ----- design/snf_mac.sv -----
// Input register, product stage and accumulate/clamp stage.
`timescale 1ns / 1ps
module snf_mac import snf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VALUE_W-1:0] input_value,
   input  logic signed [VALUE_W-1:0] weight_value,
   input  logic                      last_term,
   output logic                      sum_valid,
   input  logic                      sum_ready,
   output snf_sum_type               sum_data
);

   logic                      s1_valid_ff;
   logic signed [VALUE_W-1:0] s1_input_ff;
   logic signed [VALUE_W-1:0] s1_weight_ff;
   logic                      s1_last_ff;
   logic                      s2_valid_ff;
   logic signed [PROD_W-1:0]  s2_prod_ff;
   logic                      s2_last_ff;
   logic [ACC_W-1:0]          acc_ff;
   logic                      s3_valid_ff;
   snf_sum_type               s3_data_ff;

   logic signed [PROD_W-1:0]  prod_in;
   logic [ACC_W-1:0]          acc_sum;
   logic [ACC_W-1:0]          biased;
   logic                      clamp_low;
   logic                      clamp_high;
   snf_sum_type               s3_data_in;
   logic                      s3_open;
   logic                      s2_adv;
   logic                      s2_ready;
   logic                      s1_adv;

   assign s3_open   = !s3_valid_ff || sum_ready;
   assign s2_adv    = s2_valid_ff && (!s2_last_ff || s3_open);
   assign s2_ready  = !s2_valid_ff || s2_adv;
   assign s1_adv    = s1_valid_ff && s2_ready;
   assign req_ready = !s1_valid_ff || s1_adv;

   assign prod_in    = s1_input_ff * s1_weight_ff;
   assign acc_sum    = acc_ff + {{(ACC_W-PROD_W){s2_prod_ff[PROD_W-1]}}, s2_prod_ff};
   assign clamp_low  = $signed(acc_sum) < -ARG_LIMIT;
   assign clamp_high = $signed(acc_sum) >= ARG_LIMIT;
   assign biased     = acc_sum + ARG_LIMIT;

   always_comb begin
      s3_data_in.dot_sum          = acc_sum[SUM_W-1:0];
      s3_data_in.argument_clamped = clamp_low || clamp_high;
      if (clamp_low) begin
         s3_data_in.arg_offset = '0;
      end else if (clamp_high) begin
         s3_data_in.arg_offset = '1;
      end else begin
         s3_data_in.arg_offset = biased[ARG_LSB +: ARG_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff  <= req_valid;
            s1_input_ff  <= input_value;
            s1_weight_ff <= weight_value;
            s1_last_ff   <= last_term;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
            s2_prod_ff  <= prod_in;
            s2_last_ff  <= s1_last_ff;
         end
         if (s2_adv) begin
            acc_ff <= s2_last_ff ? '0 : acc_sum;
         end
         if (s3_open) begin
            s3_valid_ff <= s2_valid_ff && s2_last_ff;
         end
         if (s2_adv && s2_last_ff) begin
            s3_data_ff <= s3_data_in;
         end
      end
   end

   assign sum_valid = s3_valid_ff;
   assign sum_data  = s3_data_ff;

endmodule

// ----- design/snf_act.sv -----
// Sigmoid table lookup; the table read goes straight into the result register.
`timescale 1ns / 1ps
module snf_act import snf_pkg::*; #(
   parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             sum_valid,
   output logic             sum_ready,
   input  snf_sum_type      sum_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [ACT_W-1:0] activation,
   output logic [SUM_W-1:0] dot_sum,
   output logic             argument_clamped
);

   localparam int IDX_W   = $clog2(SIGMOID_ENTRIES);
   localparam int SCALE_W = ARG_W + IDX_W;
   localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

   typedef logic [SIGMOID_ENTRIES-1:0][ACT_W-1:0] rom_type;

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   function automatic logic [127:0] div_mod(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], num[i]};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return {q, r[63:0]};
   endfunction

   function automatic logic [ACT_W-1:0] scaled_ratio(input logic [63:0] num,
                                                     input logic [63:0] den);
      logic [63:0] rem;
      logic [63:0] q;
      logic [63:0] rnd;
      rem = num;
      q   = '0;
      for (int i = 0; i < 40; i++) begin
         rem = rem << 1;
         q   = q << 1;
         if (rem >= den) begin
            rem  = rem - den;
            q[0] = 1'b1;
         end
      end
      if (num >= den) begin
         q = 64'd1 << 40;
      end
      rnd = 64'd65535 * q + (64'd1 << 39);
      return rnd[55:40];
   endfunction

   function automatic rom_type build_rom();
      rom_type      rom;
      logic [63:0]  e;
      logic [63:0]  term;
      logic [63:0]  base;
      logic [63:0]  cur;
      logic [63:0]  d;
      logic [63:0]  den;
      logic [63:0]  kp;
      logic [63:0]  kn;
      logic [63:0]  en;
      logic [127:0] qr1;
      logic [127:0] qr2;
      rom  = '0;
      e    = 64'(SIGMOID_ENTRIES);
      term = ONE_Q62;
      base = ONE_Q62;
      cur  = ONE_Q62;
      for (int j = 1; j < 40; j++) begin
         if (term != 64'd0) begin
            d    = 64'(j) * e;
            qr1  = div_mod(term, d);
            qr2  = div_mod(qr1[63:0] << 3, d);
            term = (qr1[127:64] << 3) + qr2[127:64];
            if (j % 2 == 1) begin
               base = base - term;
            end else begin
               base = base + term;
            end
         end
      end
      for (int n = 0; n <= SIGMOID_ENTRIES; n++) begin
         en = e + 64'(n);
         if (en[0] == 1'b0) begin
            den = ONE_Q62 + cur;
            kp  = en >> 1;
            kn  = (e - 64'(n)) >> 1;
            if (kp < e) begin
               rom[kp[IDX_W-1:0]] = scaled_ratio(ONE_Q62, den);
            end
            if (n != 0) begin
               rom[kn[IDX_W-1:0]] = scaled_ratio(cur, den);
            end
         end
         cur = mul_q62(cur, base);
      end
      return rom;
   endfunction

   localparam rom_type SIG_ROM = build_rom();

   logic [SCALE_W-1:0] scaled;
   logic [IDX_W-1:0]   idx_raw;
   logic [IDX_W-1:0]   idx;
   logic               take;
   logic               rsp_valid_ff;
   logic [ACT_W-1:0]   act_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic               clamped_ff;

   assign scaled  = {{IDX_W{1'b0}}, sum_data.arg_offset} * SCALE_W'(SIGMOID_ENTRIES);
   assign idx_raw = scaled[ARG_W +: IDX_W];
   assign idx     = ({1'b0, idx_raw} >= (IDX_W+1)'(SIGMOID_ENTRIES))
                    ? IDX_W'(SIGMOID_ENTRIES - 1) : idx_raw;

   assign sum_ready = !rsp_valid_ff || rsp_ready;
   assign take      = sum_valid && sum_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (sum_ready) begin
            rsp_valid_ff <= sum_valid;
         end
         if (take) begin
            act_ff     <= SIG_ROM[idx];
            sum_ff     <= sum_data.dot_sum;
            clamped_ff <= sum_data.argument_clamped;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign activation       = act_ff;
   assign dot_sum          = sum_ff;
   assign argument_clamped = clamped_ff;

endmodule

// ----- design/sigmoid_neuron_forward_top.sv -----
// Top level of the streaming sigmoid neuron forward pass.
// Takes one input/weight pair (signed Q4.12) per cycle and adds the exact Q8.24 product
// into a 48-bit accumulator that wraps. The transaction with tlast set closes the vector:
// it passes through the input, product, accumulate/clamp and table-read registers, and one
// result shows the low 42 bits of the sum, a flag that the sum lay outside [-8, 8), and
// the sigmoid as unsigned Q0.16, read from a SIGMOID_ENTRIES-entry constant table built
// at elaboration; the accumulator then restarts from zero. Sustained rate is one pair per
// cycle while the response is not stalled; a stalled result holds in the output register
// while empty pipeline stages keep taking pairs.
`timescale 1ns / 1ps
module sigmoid_neuron_forward_top import snf_pkg::*; #(
   parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // input_value, weight_value
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // activation, dot_sum, zero pad
   output logic                   rsp_tuser    // argument_clamped
);

   logic             sum_valid;
   logic             sum_ready;
   snf_sum_type      sum_data;
   logic [ACT_W-1:0] activation;
   logic [SUM_W-1:0] dot_sum;

   snf_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .input_value  ($signed(req_tdata[VALUE_W-1:0])),
      .weight_value ($signed(req_tdata[2*VALUE_W-1:VALUE_W])),
      .last_term    (req_tlast),
      .sum_valid    (sum_valid),
      .sum_ready    (sum_ready),
      .sum_data     (sum_data)
   );

   snf_act #(
      .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
   ) u_act (
      .clock            (clock),
      .reset            (reset),
      .sum_valid        (sum_valid),
      .sum_ready        (sum_ready),
      .sum_data         (sum_data),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .activation       (activation),
      .dot_sum          (dot_sum),
      .argument_clamped (rsp_tuser)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, dot_sum, activation};

endmodule

// ----- design/snf_check.sv -----
// Port checker for the sigmoid neuron forward top level, with its bind.
`timescale 1ns / 1ps
module snf_check import snf_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   req_tlast,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser
);

   logic [3:0] open_ff;
   logic [3:0] open_in;
   logic       last_taken;
   logic       rsp_taken;

   assign last_taken = req_tvalid && req_tready && req_tlast;
   assign rsp_taken  = rsp_tvalid && rsp_tready;

   always_comb begin
      open_in = open_ff;
      if (last_taken && !rsp_taken) begin
         open_in = open_ff + 4'd1;
      end else if (rsp_taken && !last_taken) begin
         open_in = open_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   hold_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response payload changed while stalled");

   no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> open_ff != 4'd0)
      else $error("response without a closed vector");

   unclamped_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[ACT_W+SUM_W-1:ACT_W+27] == '0 ||
         rsp_tdata[ACT_W+SUM_W-1:ACT_W+27] == '1)
      else $error("sum outside argument range without clamp flag");

endmodule

bind sigmoid_neuron_forward_top snf_check u_check (.*);
